FILE: rtl/core/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hash unit.
// Used by shs_ctrl, shs_datapath and sha256_stream_hash_unit; no dependencies.
package shs_pkg;

   localparam int WORD_W      = 32;
   localparam int BUF_WORDS   = 16;
   localparam int DIGEST_N    = 8;
   localparam int ROUNDS      = 64;
   localparam int LEN_W       = 64;
   localparam int FILL_W      = 6;
   localparam int CNT_W       = 3;
   localparam int RND_W       = 6;
   localparam int IDX_W       = 3;
   localparam int REQ_DATA_W  = 40;

   localparam logic [CNT_W-1:0]  MAX_BYTES   = 3'd4;
   localparam logic [FILL_W:0]   BLOCK_BYTES = 7'd64;
   localparam logic [FILL_W-1:0] PAD_LIMIT   = 6'd56;
   localparam logic [7:0]        PAD_MARKER  = 8'h80;
   localparam logic [RND_W-1:0]  LAST_ROUND  = 6'd63;
   localparam logic [IDX_W-1:0]  LAST_DIGEST = 3'd7;

   localparam logic [WORD_W-1:0] INIT_HASH [DIGEST_N] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Controller to datapath commands (start may share its cycle with load, pad or pad2)
   typedef struct packed {
      logic take;    // latch request word, bump length
      logic load;    // move pending bytes into the block buffer
      logic pad;     // marker, zero fill, length if it fits
      logic pad2;    // extra padding block: zeros and length
      logic start;   // load working registers from chaining value
      logic round;   // one compression round
      logic fold;    // add working registers into chaining value
      logic emit;    // digest word taken by the consumer
   } shs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full_next;   // this load completes the block
      logic last;        // pending request ends the message
      logic len_fits;    // marker leaves room for the length
      logic round_done;  // final round this cycle
      logic out_final;   // eighth digest word on offer
   } shs_stat_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: rtl/core/sha256_stream_hash_unit.sv
// Top level of the SHA-256 stream hash unit: controller plus datapath.
// Depends on shs_pkg, shs_ctrl and shs_datapath.
//
//   channel   direction  tdata bits                         tuser  tlast
//   req_      in         [31:0] data_word, [34:32] byte_count   -      last_word
//   rsp_      out        [31:0] digest_word                   -      digest_last
//
// One request at a time: a word is taken, then stored into the block buffer;
// each time a 64-byte block fills, 64 rounds run in one shared round unit, followed
// by one fold and one reload of left-over bytes.
// A last word adds one or two padded blocks, then eight digest words.
// Synchronous reset restores the initial hash, empty buffer and zero length.
// A stalled consumer holds the digest word and blocks new requests.
module sha256_stream_hash_unit
   import shs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] data_word, [34:32] byte_count
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata,   // [31:0] digest_word
   output logic                  rsp_tlast
);

   shs_cmd_type  cmd;
   shs_stat_type stat;

   shs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   shs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_word   (req_tdata[31:0]),
      .byte_count  (req_tdata[34:32]),
      .last_word   (req_tlast),
      .stat        (stat),
      .digest_word (rsp_tdata),
      .digest_last (rsp_tlast)
   );

endmodule

FILE: rtl/core/shs_datapath.sv
// Datapath of the SHA-256 stream hash unit: block buffer, length, round logic,
// chaining value and digest selection. Depends on shs_pkg; driven by shs_ctrl.
module shs_datapath
   import shs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  shs_cmd_type         cmd,
   input  logic [WORD_W-1:0]   data_word,
   input  logic [CNT_W-1:0]    byte_count,
   input  logic                last_word,
   output shs_stat_type        stat,
   output logic [WORD_W-1:0]   digest_word,
   output logic                digest_last
);

   logic [WORD_W-1:0] buf_ff   [BUF_WORDS];
   logic [WORD_W-1:0] buf_in   [BUF_WORDS];
   logic [WORD_W-1:0] chain_ff [DIGEST_N];
   logic [WORD_W-1:0] chain_in [DIGEST_N];
   logic [WORD_W-1:0] work_ff  [DIGEST_N];
   logic [WORD_W-1:0] work_in  [DIGEST_N];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] pend_word_ff, pend_word_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic              pend_last_ff, pend_last_in;

   logic [FILL_W:0]   avail;
   logic [CNT_W-1:0]  n_bytes;
   logic [FILL_W:0]   fill_sum;
   logic [CNT_W-1:0]  cnt_cap;
   logic [FILL_W-1:0] pos;
   logic [WORD_W-1:0] t1, t2, w_new;

   // bytes that fit in the current block
   assign avail    = BLOCK_BYTES - {1'b0, fill_ff};
   assign n_bytes  = ({4'd0, pend_cnt_ff} <= avail) ? pend_cnt_ff : avail[CNT_W-1:0];
   assign fill_sum = {1'b0, fill_ff} + {4'd0, n_bytes};
   assign cnt_cap  = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;

   // round arithmetic and schedule expansion
   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[rnd_ff] + buf_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_new = buf_ff[0] + small_sigma0(buf_ff[1]) + buf_ff[9] + small_sigma1(buf_ff[14]);

   assign stat.full_next  = fill_sum[FILL_W];
   assign stat.last       = pend_last_ff;
   assign stat.len_fits   = (fill_ff < PAD_LIMIT);
   assign stat.round_done = (rnd_ff == LAST_ROUND);
   assign stat.out_final  = (idx_ff == LAST_DIGEST);

   assign digest_word = chain_ff[idx_ff];
   assign digest_last = (idx_ff == LAST_DIGEST);

   // next-state logic; start may combine with load, pad or pad2
   always_comb begin
      buf_in       = buf_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      pend_word_in = pend_word_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_last_in = pend_last_ff;
      pos          = fill_ff;

      if (cmd.take) begin
         pend_word_in = data_word;
         pend_cnt_in  = cnt_cap;
         pend_last_in = last_word;
         len_in       = len_ff + {58'd0, cnt_cap, 3'b000};
      end

      // byte insertion at the fill position
      if (cmd.load) begin
         for (int i = 0; i < 4; i++) begin
            if (CNT_W'(i) < n_bytes) begin
               pos = fill_ff + FILL_W'(i);
               buf_in[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = pend_word_ff[8*(3-i) +: 8];
            end
         end
         pend_word_in = pend_word_ff << {n_bytes, 3'b000};
         pend_cnt_in  = pend_cnt_ff - n_bytes;
         fill_in      = fill_sum[FILL_W-1:0];
      end

      // marker byte, zeros after it, length when there is room
      if (cmd.pad) begin
         for (int p = 0; p < 4 * BUF_WORDS; p++) begin
            if (FILL_W'(p) == fill_ff)
               buf_in[p / 4][8*(3 - p % 4) +: 8] = PAD_MARKER;
            else if (FILL_W'(p) > fill_ff)
               buf_in[p / 4][8*(3 - p % 4) +: 8] = 8'h00;
         end
         if (stat.len_fits) begin
            buf_in[14] = len_ff[63:32];
            buf_in[15] = len_ff[31:0];
         end
      end

      if (cmd.pad2) begin
         for (int w = 0; w < BUF_WORDS - 2; w++)
            buf_in[w] = '0;
         buf_in[14] = len_ff[63:32];
         buf_in[15] = len_ff[31:0];
      end

      if (cmd.start) begin
         work_in = chain_ff;
         rnd_in  = '0;
      end

      // one round; the buffer doubles as the schedule window
      if (cmd.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         for (int j = 0; j < BUF_WORDS - 1; j++)
            buf_in[j] = buf_ff[j+1];
         buf_in[BUF_WORDS-1] = w_new;
         rnd_in = rnd_ff + 1'b1;
      end

      if (cmd.fold) begin
         for (int k = 0; k < DIGEST_N; k++)
            chain_in[k] = chain_ff[k] + work_ff[k];
      end

      // after the eighth word, back to a fresh message
      if (cmd.emit) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_DIGEST) begin
            chain_in = INIT_HASH;
            fill_in  = '0;
            len_in   = '0;
         end
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff    <= INIT_HASH;
         fill_ff     <= '0;
         len_ff      <= '0;
         rnd_ff      <= '0;
         idx_ff      <= '0;
         pend_cnt_ff <= '0;
      end else begin
         chain_ff    <= chain_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         rnd_ff      <= rnd_in;
         idx_ff      <= idx_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      buf_ff       <= buf_in;
      work_ff      <= work_in;
      pend_word_ff <= pend_word_in;
      pend_last_ff <= pend_last_in;
   end

endmodule

FILE: rtl/core/shs_ctrl.sv
// Sequencing state machine of the SHA-256 stream hash unit.
// Depends on shs_pkg; issues commands to shs_datapath and runs both handshakes.
module shs_ctrl
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  shs_stat_type stat,
   output shs_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_PAD2  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_FOLD  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;   // where to go after a compression

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (stat.full_next) begin
               cmd.start = 1'b1;
               ret_in    = ST_LOAD;
               state_in  = ST_ROUND;
            end else if (stat.last) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.pad   = 1'b1;
            cmd.start = 1'b1;
            ret_in    = stat.len_fits ? ST_OUT : ST_PAD2;
            state_in  = ST_ROUND;
         end
         ST_PAD2: begin
            cmd.pad2  = 1'b1;
            cmd.start = 1'b1;
            ret_in    = ST_OUT;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.round_done)
               state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cmd.emit = 1'b1;
               if (stat.out_final)
                  state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule
